// ===== design/keyword_substitution_decoder_unit_defines.svh =====
// Assertion macros for the keyword substitution decoder.
`ifndef KEYWORD_SUBSTITUTION_DECODER_UNIT_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_DECODER_UNIT_DEFINES_SVH

// Checked on every edge outside reset.
`define KWSD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define KWSD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/kwsd_pkg.sv =====
// Shared types, constants and helpers for the keyword substitution decoder.
package kwsd_pkg;

    localparam int LETTERS    = 26;
    localparam int IDX_W      = 5;
    localparam logic [7:0] UPPER_BASE = 8'd65;
    localparam logic [7:0] CASE_GAP   = 8'd32;
    localparam logic [IDX_W-1:0] LAST_LETTER = IDX_W'(LETTERS - 1);
    localparam logic [IDX_W-1:0] FULL_FILL   = IDX_W'(LETTERS);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_KEY    = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_DECODE = 2'd3
    } op_t;

    typedef struct packed {
        logic             is_letter;
        logic [IDX_W-1:0] idx;
    } letter_t;

    // Position-memory access from the control logic.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    function automatic letter_t letter_of(input logic [7:0] b);
        letter_t r;
        logic [7:0] d;
        r = '0;
        if (b >= UPPER_BASE && b < UPPER_BASE + 8'(LETTERS)) begin
            d = b - UPPER_BASE;
            r.is_letter = 1'b1;
            r.idx = d[IDX_W-1:0];
        end
        else if (b >= UPPER_BASE + CASE_GAP && b < UPPER_BASE + CASE_GAP + 8'(LETTERS)) begin
            d = b - UPPER_BASE - CASE_GAP;
            r.is_letter = 1'b1;
            r.idx = d[IDX_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/kwsd_pos_mem.sv =====
// Letter-to-position memory: one write port, one registered read port.
module kwsd_pos_mem
    import kwsd_pkg::*;
(
    input  logic             clk,
    input  mem_req_t         req,
    output logic [IDX_W-1:0] rd_data
);

    logic [IDX_W-1:0] mem [LETTERS];
    logic [IDX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/keyword_substitution_decoder_unit.sv =====
// Keyword substitution decoder top level: key build, close walk and text decode.
// Clear and key bytes stay in idle; the next transaction is accepted on the following cycle.
// Decode reads the position memory through its registered read port, then the lookup
// state loads the output register once it is free; until then no further input is taken.
// Close walks all 26 letters through the memory write port, taking no input meanwhile.
// Reset (rst_n low, async) empties the key and the output; memory contents are kept.
`include "keyword_substitution_decoder_unit_defines.svh"

module keyword_substitution_decoder_unit
    import kwsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_CLOSE  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [LETTERS-1:0]     seen_reg, seen_next;
    logic [IDX_W-1:0]       fill_reg, fill_next;
    logic [IDX_W-1:0]       walk_reg, walk_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             char_out_reg, char_out_next;

    mem_req_t               mem_req;
    logic [IDX_W-1:0]       rd_data;
    letter_t                in_letter;
    letter_t                held_letter;
    logic                   accept;
    logic                   out_load;

    kwsd_pos_mem u_pos_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign in_letter   = letter_of(char_in);
    assign held_letter = letter_of(byte_reg);
    assign out_load    = (state_reg == ST_LOOKUP) && (!out_valid_reg || out_ready);

    // Writes and reads never share an edge: one transaction per edge, and any earlier
    // write has landed before a decode reads, so no forwarding is needed.
    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        fill_next      = fill_reg;
        walk_next      = walk_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg;
        char_out_next  = char_out_reg;
        mem_req        = '0;
        mem_req.waddr  = walk_reg;
        mem_req.wdata  = fill_reg;
        mem_req.raddr  = in_letter.idx;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(op))
                        OP_CLEAR:
                        begin
                            seen_next = '0;
                            fill_next = '0;
                        end
                        OP_KEY:
                        begin
                            if (in_letter.is_letter && !seen_reg[in_letter.idx]
                                && fill_reg < FULL_FILL)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = in_letter.idx;
                                seen_next[in_letter.idx] = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_CLOSE:
                        begin
                            walk_next  = '0;
                            state_next = ST_CLOSE;
                        end
                        OP_DECODE:
                        begin
                            mem_req.re = in_letter.is_letter;
                            byte_next  = char_in;
                            state_next = ST_LOOKUP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    char_out_next  = held_letter.is_letter
                                   ? UPPER_BASE + {3'b000, rd_data}
                                   : byte_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_CLOSE:
            begin
                if (!seen_reg[walk_reg] && fill_reg < FULL_FILL)
                begin
                    mem_req.we = 1'b1;
                    seen_next[walk_reg] = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                walk_next = walk_reg + 1'b1;
                if (walk_reg == LAST_LETTER)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            fill_reg      <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            fill_reg      <= fill_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        char_out_reg <= char_out_next;
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;

    `KWSD_ASSERT(a_fill_matches_seen, $countones(seen_reg) == 32'(fill_reg), "fill count disagrees with seen letters")
    `KWSD_ASSERT(a_close_fills_all, (state_reg == ST_CLOSE && walk_reg == LAST_LETTER) |=> (seen_reg == '1 && fill_reg == FULL_FILL), "close left letters unplaced")
    `KWSD_ASSERT(a_no_rw_collision, !(mem_req.we && mem_req.re), "position memory read and write on one edge")
    `KWSD_ASSERT(a_decode_looks_up, (accept && op_t'(op) == OP_DECODE) |=> (state_reg == ST_LOOKUP), "decode did not enter lookup")

endmodule

// ===== tb/sv/keyword_substitution_decoder_checker.sv =====
// Checker for the keyword substitution decoder: tracks the cipher key and compares decoded bytes.
module keyword_substitution_decoder_checker
    import kwsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] char_in,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] char_out,
    output int         errors,
    output int         pending,
    output int         decoded
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [LETTERS-1:0] seen_mask;
    logic [IDX_W-1:0]   fill_count;
    logic [IDX_W-1:0]   position [LETTERS];
    logic [7:0]         plain_q [$];

    initial
    begin
        errors  = 0;
        pending = 0;
        decoded = 0;
        seen_mask  = '0;
        fill_count = '0;
    end

    // Folds lower case onto upper case; idx is only meaningful when the result is 1.
    function automatic logic letter_slot(input logic [7:0] b, output logic [IDX_W-1:0] idx);
        logic [7:0] upper;
        upper = (b >= UPPER_BASE + CASE_GAP) ? b - CASE_GAP : b;
        idx = IDX_W'(upper - UPPER_BASE);
        return (upper >= UPPER_BASE) && (upper < UPPER_BASE + 8'(LETTERS));
    endfunction

    function automatic void add_letter(input logic [IDX_W-1:0] idx);
        if (fill_count < FULL_FILL && !seen_mask[idx])
        begin
            position[idx]  = fill_count;
            fill_count     = fill_count + 1'b1;
            seen_mask[idx] = 1'b1;
        end
    endfunction

    function automatic void key_or_decode(input op_t code, input logic [7:0] b);
        logic [IDX_W-1:0] idx;
        logic             hit;
        hit = letter_slot(b, idx);
        case (code)
            OP_CLEAR:
            begin
                seen_mask  = '0;
                fill_count = '0;
            end
            OP_KEY:
                if (hit)
                    add_letter(idx);
            OP_CLOSE:
                for (int k = 0; k < LETTERS; k++)
                    add_letter(IDX_W'(k));
            default:
                plain_q.push_back(hit ? UPPER_BASE + 8'(position[idx]) : b);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] want;
        if (!rst_n)
        begin
            seen_mask  = '0;
            fill_count = '0;
            plain_q.delete();
        end
        else
        begin
            // results always trail their transaction, so retire first
            if (out_valid && out_ready)
            begin
                if (plain_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: char_out %h with no decode pending", $time, char_out);
                end
                else
                begin
                    want = plain_q.pop_front();
                    decoded++;
                    if (char_out !== want)
                    begin
                        errors++;
                        $display("%0t: char_out mismatch, expected %h actual %h",
                                 $time, want, char_out);
                    end
                end
            end
            if (in_valid && in_ready)
                key_or_decode(op_t'(op), char_in);
        end
        pending = plain_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the keyword substitution decoder testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kwsd_pkg::*;

    localparam int ITEMS       = 700;
    localparam int STALL_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] op;
    logic [7:0] char_in;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] char_out;

    int errors;
    int pending;
    int decoded;
    int sent;
    int key_runs;
    int full_keys;
    int stall_cycles;
    int send_burst;
    int recv_burst;

    keyword_substitution_decoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .char_in  (char_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .char_out (char_out)
    );

    keyword_substitution_decoder_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .char_in  (char_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .char_out (char_out),
        .errors   (errors),
        .pending  (pending),
        .decoded  (decoded)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle cycles per transaction, with occasional back-to-back stretches.
    function automatic int idle_draw(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            burst = $urandom_range(10, 40);
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] b;
        b = UPPER_BASE + 8'($urandom_range(0, LETTERS - 1));
        if ($urandom_range(0, 1) != 0)
            b = b + CASE_GAP;
        return b;
    endfunction

    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 9) < 7)
            return random_letter();
        return 8'($urandom_range(0, 255));
    endfunction

    // Entered at a rising edge; returns at the edge that accepts the transaction.
    task automatic send(input op_t code, input logic [7:0] b);
        int gap;
        gap = idle_draw(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        char_in  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    // A full 26-letter key in shuffled order, then a few bytes that must be ignored.
    task automatic send_full_key();
        logic [7:0] order [LETTERS];
        logic [7:0] t;
        int         j;
        for (int k = 0; k < LETTERS; k++)
            order[k] = UPPER_BASE + 8'(k);
        for (int k = LETTERS - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (int k = 0; k < LETTERS; k++)
            send(OP_KEY, order[k] + (($urandom_range(0, 1) != 0) ? CASE_GAP : 8'd0));
        repeat (3) send(OP_KEY, random_letter());
        full_keys++;
    endtask

    initial
    begin
        out_ready = 1'b0;
        repeat (11) @(posedge clk);
        forever
        begin
            int gap;
            gap = idle_draw(recv_burst);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        stall_cycles = 0;
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("** keyword_substitution_decoder_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int len;
        in_valid   = 1'b0;
        op         = OP_CLEAR;
        char_in    = 8'h00;
        rst_n      = 1'b0;
        sent       = 0;
        key_runs   = 0;
        full_keys  = 0;
        send_burst = 0;
        recv_burst = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // pass-through bytes around the letter ranges and at the byte extremes
        send(OP_DECODE, 8'h00);
        send(OP_DECODE, 8'hFF);
        send(OP_DECODE, "@");
        send(OP_DECODE, "{");
        send(OP_DECODE, 8'h80);
        // key: both letter extremes, a repeat in the other case, a digit, a high byte
        send(OP_KEY, "Z");
        send(OP_KEY, "a");
        send(OP_KEY, "z");
        send(OP_KEY, "5");
        send(OP_KEY, 8'hC1);
        // decode before close, only letters already in the key
        send(OP_DECODE, "Z");
        send(OP_DECODE, "z");
        send(OP_DECODE, "A");
        send(OP_DECODE, "a");
        // repeated close, then a key byte that must be ignored
        send(OP_CLOSE, 8'h00);
        send(OP_CLOSE, 8'hFF);
        send(OP_KEY, "Q");
        send(OP_DECODE, "M");
        send(OP_DECODE, "b");
        // new key after clear; Q still holds its entry from the old alphabet
        send(OP_CLEAR, 8'hFF);
        send(OP_KEY, "m");
        send(OP_DECODE, "M");
        send(OP_DECODE, "Q");
        send(OP_CLOSE, 8'h00);
        send(OP_DECODE, "A");

        while (sent < ITEMS)
        begin
            if ($urandom_range(0, 99) < 15)
                send(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else
            begin
                key_runs++;
                send(OP_CLEAR, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 19) == 0)
                    send_full_key();
                else
                begin
                    len = $urandom_range(1, 12);
                    repeat (len)
                        send(OP_KEY, ($urandom_range(0, 9) == 0) ?
                             8'($urandom_range(0, 255)) : random_letter());
                end
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 4)) send(OP_DECODE, text_byte());
                // occasionally left open so decodes see a partial key
                if ($urandom_range(0, 9) != 0)
                    send(OP_CLOSE, 8'($urandom_range(0, 255)));
                len = $urandom_range(4, 24);
                repeat (len) send(OP_DECODE, text_byte());
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d transactions over %0d random keys (%0d full 26-letter keys).",
                 sent, key_runs, full_keys);
        $display("Checked %0d decoded bytes, %0d mismatches.", decoded, errors);
        if (errors == 0)
            $display("** keyword_substitution_decoder_unit: PASSED **");
        else
            $display("** keyword_substitution_decoder_unit: FAILED **");
        $finish;
    end

endmodule
